// ===== design/lzo_pkg.sv =====
`timescale 1ns / 1ps
package lzo_pkg;
  localparam int unsigned HistDepth = 65536;
  localparam int unsigned HistAw = $clog2(HistDepth);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    PH_FIRST, PH_TOK_RUN, PH_TOK_MATCH, PH_LIT_EXT, PH_LIT_COPY, PH_M_EXT,
    PH_DIST0, PH_DIST1, PH_DIST_SHORT, PH_MATCH_COPY, PH_TRAIL, PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    K_DATA = 3'd0, K_END = 3'd1, K_LOOKBEHIND = 3'd2, K_OVERRUN = 3'd3,
    K_BADCMD = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE, OP_LIT, OP_COPY, OP_FINISH
  } op_e;

  // request handed from parser to writer
  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [15:0] offset;
    kind_e       kind;
    logic [24:0] count;
  } job_t;
endpackage

// ===== design/lzo_stream_if.sv =====
`timescale 1ns / 1ps
interface lzo_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;
  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink (input valid, input cmd, input in_byte, output ready);
endinterface

interface lzo_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  kind;
  logic [24:0] consumed_count;
  logic        last;
  modport source (output valid, output out_byte, output kind, output consumed_count,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input consumed_count,
                input last, output ready);
endinterface

// ===== design/lzo_parser.sv =====
`timescale 1ns / 1ps
module lzo_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [23:0]   output_length_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cmd_i,
  input  logic [7:0]    in_byte_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output lzo_pkg::job_t job_o
);
  import lzo_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  tok_q, tok_d;
  logic [23:0] plen_q, plen_d;
  logic [15:0] dist_q, dist_d;
  logic [1:0]  trail_q, trail_d;
  logic        alr_q, alr_d;
  logic [23:0] wr_q, wr_d;
  logic [24:0] cons_q, cons_d;
  job_t        job;
  logic        fire;

  assign in_ready_o = job_ready_i;
  assign fire = in_valid_i && job_ready_i;
  assign job_valid_o = fire && (job.op != OP_NONE);
  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      tok_q   <= '0;
      plen_q  <= '0;
      dist_q  <= '0;
      trail_q <= '0;
      alr_q   <= 1'b0;
      wr_q    <= '0;
      cons_q  <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      tok_q   <= tok_d;
      plen_q  <= plen_d;
      dist_q  <= dist_d;
      trail_q <= trail_d;
      alr_q   <= alr_d;
      wr_q    <= wr_d;
      cons_q  <= cons_d;
    end
  end

  always_comb begin
    logic [25:0] need;
    logic [25:0] v;
    logic [7:0]  b;
    logic [7:0]  t;
    logic        do_copy;
    logic        do_lits;
    logic [25:0] cdist;
    phase_d = phase_q;
    tok_d   = tok_q;
    plen_d  = plen_q;
    dist_d  = dist_q;
    trail_d = trail_q;
    alr_d   = alr_q;
    wr_d    = wr_q;
    cons_d  = cons_q;
    job     = '{op: OP_NONE, data: 8'd0, offset: 16'd0, kind: K_DATA, count: 25'd0};
    b = in_byte_i;
    t = tok_q;
    need = '0;
    v = '0;
    do_copy = 1'b0;
    do_lits = 1'b0;
    cdist = '0;
    if (phase_q == PH_HALT || (phase_q == PH_MATCH_COPY) != cmd_i) begin
      job.op = OP_FINISH;
      job.kind = K_BADCMD;
      phase_d = PH_HALT;
    end else if (phase_q == PH_MATCH_COPY) begin
      job.op = OP_COPY;
      job.offset = dist_q;
      wr_d = wr_q + 24'd1;
      plen_d = plen_q - 24'd1;
      if (plen_d == '0) phase_d = (trail_q != '0) ? PH_TRAIL : PH_TOK_RUN;
    end else begin
      if (cons_q != '1) cons_d = cons_q + 25'd1;
      case (phase_q)
        PH_FIRST, PH_TOK_RUN, PH_TOK_MATCH: begin
          if (phase_q == PH_FIRST && b > 8'd17) begin
            v = {18'd0, b} - 26'd17;
            if (v < 26'd4) begin
              trail_d = v[1:0];
              phase_d = PH_TRAIL;
            end else begin
              alr_d = 1'b1;
              need = v;
              do_lits = 1'b1;
            end
          end else if (phase_q == PH_TOK_MATCH || b >= 8'd16) begin
            tok_d = b;
            if (b >= 8'd64) begin
              plen_d = {21'd0, b[7:5]} + 24'd1;
              trail_d = b[1:0];
              phase_d = PH_DIST_SHORT;
            end else if (b >= 8'd16) begin
              v = (b >= 8'd32) ? {21'd0, b[4:0]} : {23'd0, b[2:0]};
              if (v == '0) begin
                plen_d = '0;
                phase_d = PH_M_EXT;
              end else begin
                plen_d = v[23:0] + 24'd2;
                phase_d = PH_DIST0;
              end
            end else begin
              trail_d = b[1:0];
              plen_d = alr_q ? 24'd3 : 24'd2;
              phase_d = PH_DIST_SHORT;
            end
          end else if (b == 8'd0) begin
            plen_d = '0;
            phase_d = PH_LIT_EXT;
          end else begin
            need = {18'd0, b} + 26'd3;
            do_lits = 1'b1;
          end
        end
        PH_LIT_EXT, PH_M_EXT: begin
          if (b == 8'd0) begin
            plen_d = (plen_q > 24'hFFFF00) ? 24'hFFFFFF : plen_q + 24'd255;
          end else if (phase_q == PH_LIT_EXT) begin
            need = {2'd0, plen_q} + 26'd18 + {18'd0, b};
            do_lits = 1'b1;
          end else begin
            v = {2'd0, plen_q} + ((t >= 8'd32) ? 26'd33 : 26'd9) + {18'd0, b};
            if (v > 26'hFFFFFF) begin
              job.op = OP_FINISH;
              job.kind = K_OVERRUN;
              phase_d = PH_HALT;
            end else begin
              plen_d = v[23:0];
              phase_d = PH_DIST0;
            end
          end
        end
        PH_LIT_COPY: begin
          plen_d = plen_q - 24'd1;
          if (plen_d == '0) begin
            alr_d = 1'b1;
            phase_d = PH_TOK_MATCH;
          end
          job.op = OP_LIT;
          job.data = b;
          wr_d = wr_q + 24'd1;
        end
        PH_DIST0: begin
          trail_d = b[1:0];
          // m4 token bit 3 selects the upper 16k window
          dist_d = {10'd0, b[7:2]} + ((t < 8'd32) ? {1'b0, t[3], 14'd0} : 16'd0);
          phase_d = PH_DIST1;
        end
        PH_DIST1: begin
          v = {10'd0, dist_q} + {12'd0, b, 6'd0};
          if (t >= 8'd32) begin
            cdist = v + 26'd1;
            do_copy = 1'b1;
          end else if (v == '0) begin
            job.op = OP_FINISH;
            phase_d = PH_HALT;
            if (wr_q != output_length_i) job.kind = K_OVERRUN;
            else begin
              job.kind = K_END;
              job.count = cons_d;
            end
          end else begin
            cdist = v + 26'h4000;
            do_copy = 1'b1;
          end
        end
        PH_DIST_SHORT: begin
          if (t >= 8'd64) cdist = 26'd1 + {23'd0, t[4:2]} + {15'd0, b, 3'd0};
          else cdist = 26'd1 + {20'd0, t[7:2]} + {16'd0, b, 2'd0}
                       + (alr_q ? 26'h800 : 26'd0);
          do_copy = 1'b1;
        end
        PH_TRAIL: begin
          if ({2'd0, wr_q} + {24'd0, trail_q} > {2'd0, output_length_i}) begin
            job.op = OP_FINISH;
            job.kind = K_OVERRUN;
            phase_d = PH_HALT;
          end else begin
            trail_d = trail_q - 2'd1;
            if (trail_d == '0) begin
              alr_d = 1'b0;
              phase_d = PH_TOK_MATCH;
            end
            job.op = OP_LIT;
            job.data = b;
            wr_d = wr_q + 24'd1;
          end
        end
        default: begin
          job.op = OP_FINISH;
          job.kind = K_BADCMD;
          phase_d = PH_HALT;
        end
      endcase
      if (do_lits) begin
        if ({2'd0, wr_q} + need > {2'd0, output_length_i}) begin
          job.op = OP_FINISH;
          job.kind = K_OVERRUN;
          phase_d = PH_HALT;
        end else begin
          plen_d = need[23:0];
          phase_d = PH_LIT_COPY;
        end
      end
      if (do_copy) begin
        if (cdist > {2'd0, wr_q}) begin
          job.op = OP_FINISH;
          job.kind = K_LOOKBEHIND;
          phase_d = PH_HALT;
        end else if ({2'd0, wr_q} + {2'd0, plen_d} > {2'd0, output_length_i}) begin
          job.op = OP_FINISH;
          job.kind = K_OVERRUN;
          phase_d = PH_HALT;
        end else begin
          dist_d = cdist[15:0];
          phase_d = PH_MATCH_COPY;
        end
      end
    end
  end
endmodule

// ===== design/lzo_writer.sv =====
`timescale 1ns / 1ps
module lzo_writer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  lzo_pkg::job_t job_i,
  lzo_out_if.source     out_o
);
  import lzo_pkg::*;

  // small job queue decouples parser from history access and output
  localparam int unsigned QAw = $clog2(QueueDepth);
  job_t             q_mem_q [QueueDepth];
  logic [QAw-1:0]   q_rd_q, q_wr_q;
  logic [QAw:0]     q_cnt_q;
  logic             q_pop;
  job_t             head;

  logic [7:0]       hist_q [HistDepth];
  logic [HistAw-1:0] wptr_q;
  logic [7:0]       rd_data_q;
  logic [7:0]       last_wr_q;
  logic             fwd_q;

  // stage 1: memory access; stage 2: output register
  logic             s1_valid_q;
  job_t             s1_q;
  logic             s2_valid_q;
  logic [7:0]       s2_byte_q;
  kind_e            s2_kind_q;
  logic [24:0]      s2_count_q;
  logic             s2_last_q;
  logic             s2_free, s1_adv;
  logic [HistAw-1:0] src_addr;

  assign job_ready_o = (q_cnt_q < QueueDepth[QAw:0]) || q_pop;
  assign head = q_mem_q[q_rd_q];
  assign s2_free = !s2_valid_q || out_o.ready;
  assign s1_adv = !s1_valid_q || s2_free;
  assign q_pop = (q_cnt_q != '0) && s1_adv;
  assign src_addr = wptr_q - head.offset[HistAw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_rd_q <= '0;
      q_wr_q <= '0;
      q_cnt_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wptr_q <= '0;
    end else begin
      if (job_valid_i && job_ready_o) q_wr_q <= q_wr_q + 1'b1;
      if (q_pop) q_rd_q <= q_rd_q + 1'b1;
      q_cnt_q <= q_cnt_q + {{QAw{1'b0}}, job_valid_i && job_ready_o}
                 - {{QAw{1'b0}}, q_pop};
      if (s1_adv) s1_valid_q <= q_pop;
      if (s2_free) s2_valid_q <= s1_valid_q;
      if (q_pop && (head.op == OP_LIT || head.op == OP_COPY)) wptr_q <= wptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) q_mem_q[q_wr_q] <= job_i;
    if (s1_adv) s1_q <= head;
  end

  // history: one write port (literal or previous copy result), one read port
  always_ff @(posedge clk_i) begin
    if (q_pop && head.op == OP_COPY) begin
      rd_data_q <= hist_q[src_addr];
    end
  end

  logic [7:0] s1_byte;
  assign s1_byte = (s1_q.op == OP_COPY) ? (fwd_q ? last_wr_q : rd_data_q) : s1_q.data;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      // distance 1 reads the byte being produced in stage 1
      fwd_q <= s1_valid_q && head.offset == 16'd1 &&
               (s1_q.op == OP_LIT || s1_q.op == OP_COPY);
      if (s1_valid_q && (s1_q.op == OP_LIT || s1_q.op == OP_COPY)) begin
        hist_q[wptr_q - 1'b1] <= s1_byte;
        last_wr_q <= s1_byte;
      end
    end
    if (s2_free && s1_valid_q) begin
      s2_byte_q  <= (s1_q.op == OP_FINISH) ? 8'd0 : s1_byte;
      s2_kind_q  <= (s1_q.op == OP_FINISH) ? s1_q.kind : K_DATA;
      s2_count_q <= (s1_q.op == OP_FINISH) ? s1_q.count : 25'd0;
      s2_last_q  <= (s1_q.op == OP_FINISH);
    end
  end

  assign out_o.valid = s2_valid_q;
  assign out_o.out_byte = s2_byte_q;
  assign out_o.kind = s2_kind_q;
  assign out_o.consumed_count = s2_count_q;
  assign out_o.last = s2_last_q;
endmodule

// ===== design/lzo1x_stream_decompressor_top.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// in_if     in   valid/ready    cmd, in_byte
// out_if    out  valid/ready    out_byte, kind, consumed_count, last
// cfg       in   cfg_we_i       cfg_wdata_i (output_length)
// one item per cycle unless out_if stalls; parser decides in the accept
// cycle; the result goes via queue, history read stage, output register.
// no clearing pass after reset; history is only read where written.
// a stalled output backs up the two-entry queue and then in_if.ready.
module lzo1x_stream_decompressor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  lzo_in_if.sink      in_if,
  lzo_out_if.source   out_if
);
  import lzo_pkg::*;

  logic [23:0] olen_q;
  logic        job_valid, job_ready;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) olen_q <= '0;
    else if (cfg_we_i) olen_q <= cfg_wdata_i;
  end

  lzo_parser u_parser (
    .clk_i, .rst_ni, .output_length_i(olen_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .cmd_i(in_if.cmd), .in_byte_i(in_if.in_byte),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  lzo_writer u_writer (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .out_o(out_if)
  );

  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ((out_if.kind == K_DATA) != out_if.last)) else $error("kind/last");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.kind))
    else $error("output dropped");
  a_job_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> job_ready) else $error("job without room");
endmodule

// ===== test/tb_lzo1x_stream_decompressor_top.sv =====
`timescale 1ns / 1ps
module tb_lzo1x_stream_decompressor_top;
  import lzo_pkg::*;

  localparam int unsigned Max24 = 24'hFFFFFF;
  localparam int unsigned Max25 = 25'h1FFFFFF;
  localparam int unsigned StallLimit = 5000;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
  } request_t;

  typedef struct {
    logic [7:0]  out_byte;
    kind_e       kind;
    logic [24:0] count;
    logic        last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [23:0] cfg_wdata_i;

  lzo_in_if  in_if ();
  lzo_out_if out_if ();

  lzo1x_stream_decompressor_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  request_t    request_q[$];
  result_t     decoded_q[$];
  int unsigned fail_cnt;
  int unsigned sent_cnt;
  int unsigned quiet_cycles;

  // ---------------- decoder prediction ----------------
  phase_e      ph;
  int unsigned tok, plen, mdist, trl, alr, bw, bc, olen;
  logic [7:0]  hist[HistDepth];
  result_t     nxt;
  bit          got;

  task automatic close_out(kind_e k, int unsigned c);
    nxt = '{8'd0, k, c[24:0], 1'b1};
    got = 1;
    ph = PH_HALT;
  endtask

  task automatic put_byte(int unsigned v);
    hist[bw % HistDepth] = v[7:0];
    bw = (bw + 1) & Max24;
    nxt = '{v[7:0], K_DATA, 25'd0, 1'b0};
    got = 1;
  endtask

  function automatic bit room(longint unsigned n);
    longint unsigned s;
    s = bw;
    s += n;
    return s <= olen;
  endfunction

  function automatic int unsigned sat255(int unsigned v);
    return (v + 255 > Max24) ? Max24 : v + 255;
  endfunction

  task automatic match_tok(int unsigned t);
    int unsigned len;
    tok = t;
    if (t >= 64) begin
      plen = (t >> 5) + 1;
      trl = t & 3;
      ph = PH_DIST_SHORT;
    end else if (t >= 16) begin
      len = (t >= 32) ? (t & 31) : (t & 7);
      if (len == 0) begin
        plen = 0;
        ph = PH_M_EXT;
      end else begin
        plen = len + 2;
        ph = PH_DIST0;
      end
    end else begin
      trl = t & 3;
      plen = alr ? 3 : 2;
      ph = PH_DIST_SHORT;
    end
  endtask

  task automatic start_copy(int unsigned d);
    if (d > bw) close_out(K_LOOKBEHIND, 0);
    else if (!room(plen)) close_out(K_OVERRUN, 0);
    else begin
      mdist = d & 16'hFFFF;
      ph = PH_MATCH_COPY;
    end
  endtask

  task automatic start_lits(int unsigned total);
    if (!room(total)) close_out(K_OVERRUN, 0);
    else begin
      plen = total & Max24;
      ph = PH_LIT_COPY;
    end
  endtask

  task automatic tok_run(int unsigned b);
    if (b >= 16) match_tok(b);
    else if (b == 0) begin
      plen = 0;
      ph = PH_LIT_EXT;
    end else start_lits(b + 3);
  endtask

  task automatic feed_byte(int unsigned b);
    int unsigned t;
    int unsigned v;
    t = tok;
    if (bc < Max25) bc++;
    case (ph)
      PH_FIRST: begin
        if (b > 17) begin
          v = b - 17;
          if (v < 4) begin
            trl = v;
            ph = PH_TRAIL;
          end else begin
            alr = 1;
            start_lits(v);
          end
        end else tok_run(b);
      end
      PH_TOK_RUN: tok_run(b);
      PH_TOK_MATCH: match_tok(b);
      PH_LIT_EXT: begin
        if (b == 0) plen = sat255(plen);
        else start_lits(plen + 15 + b + 3);
      end
      PH_LIT_COPY: begin
        plen = (plen - 1) & Max24;
        if (plen == 0) begin
          alr = 1;
          ph = PH_TOK_MATCH;
        end
        put_byte(b);
      end
      PH_M_EXT: begin
        if (b == 0) plen = sat255(plen);
        else begin
          v = plen + ((t >= 32) ? 31 : 7) + b + 2;
          if (v > Max24) close_out(K_OVERRUN, 0);
          else begin
            plen = v;
            ph = PH_DIST0;
          end
        end
      end
      PH_DIST0: begin
        trl = b & 3;
        mdist = (b >> 2) + ((t < 32) ? ((t & 8) << 11) : 0);
        ph = PH_DIST1;
      end
      PH_DIST1: begin
        v = mdist + (b << 6);
        if (t >= 32) start_copy(v + 1);
        else if (v == 0) begin
          // end marker
          if (bw != olen) close_out(K_OVERRUN, 0);
          else close_out(K_END, bc);
        end else start_copy(v + 16'h4000);
      end
      PH_DIST_SHORT: begin
        if (t >= 64) v = 1 + ((t >> 2) & 7) + (b << 3);
        else v = 1 + (t >> 2) + (b << 2) + (alr ? 12'h800 : 0);
        start_copy(v);
      end
      PH_TRAIL: begin
        if (!room(trl)) close_out(K_OVERRUN, 0);
        else begin
          trl = (trl - 1) & 3;
          if (trl == 0) begin
            alr = 0;
            ph = PH_TOK_MATCH;
          end
          put_byte(b);
        end
      end
      default: close_out(K_BADCMD, 0);
    endcase
  endtask

  task automatic decode_request(logic cmd, logic [7:0] b);
    int unsigned src;
    got = 0;
    if (ph == PH_HALT) close_out(K_BADCMD, 0);
    else if (ph == PH_MATCH_COPY) begin
      if (cmd != 1'b1) close_out(K_BADCMD, 0);
      else begin
        src = (bw - mdist) % HistDepth;
        plen = (plen - 1) & Max24;
        if (plen == 0) ph = (trl != 0) ? PH_TRAIL : PH_TOK_RUN;
        put_byte(hist[src]);
      end
    end else if (cmd != 1'b0) close_out(K_BADCMD, 0);
    else feed_byte(b);
    if (got) decoded_q.push_back(nxt);
  endtask

  // ---------------- stream building ----------------
  int unsigned gw;     // bytes the built stream will have written
  int          gstate; // 0 first byte, 1 token after match, 2 token after literals
  bit          ga;     // last group was a literal run

  task automatic push_feed(int unsigned b);
    request_q.push_back('{1'b0, b[7:0]});
    sent_cnt++;
  endtask

  task automatic push_pulls(int unsigned n);
    repeat (n) begin
      request_q.push_back('{1'b1, 8'($urandom)});
      sent_cnt++;
    end
  endtask

  task automatic push_bytes(int unsigned n);
    repeat (n) push_feed($urandom_range(255, 0));
  endtask

  task automatic gen_lits(int unsigned n);
    int unsigned z;
    if (gstate == 0 && n <= 238) push_feed(n + 17);
    else if (n <= 18) push_feed(n - 3);
    else begin
      z = (n - 19) / 255;
      push_feed(0);
      repeat (z) push_feed(0);
      push_feed(n - 18 - 255 * z);
    end
    push_bytes(n);
    gw += n;
    gstate = 2;
    ga = 1;
  endtask

  task automatic gen_first_trail(int unsigned n);
    push_feed(17 + n);
    push_bytes(n);
    gw += n;
    gstate = 2;
    ga = 0;
  endtask

  // form: 0 short after literals, 1 two-byte, 2 mid-range, 3 mid-range long
  task automatic gen_match(int form, int trail);
    int unsigned n, d, len, x, z, b;
    int          f;
    bit          m1_ok;
    n = (trail < 0) ? $urandom_range(3, 0) : trail;
    m1_ok = (gstate == 2) && (ga ? gw >= 2049 : gw >= 1);
    f = form;
    if (f < 0) begin
      do f = $urandom_range(3, 0); while (f == 0 && !m1_ok);
      if (f == 3 && $urandom_range(2, 0) != 0) f = 2;
    end
    case (f)
      0: begin
        len = ga ? 3 : 2;
        if (ga) d = $urandom_range((gw < 3072) ? gw : 3072, 2049);
        else d = $urandom_range((gw < 1024) ? gw : 1024, 1);
        x = d - 1 - (ga ? 12'h800 : 0);
        push_feed(((x & 3) << 2) | n);
        push_feed(x >> 2);
      end
      1: begin
        len = $urandom_range(8, 3);
        d = $urandom_range((gw < 2048) ? gw : 2048, 1);
        push_feed(((len - 1) << 5) | (((d - 1) & 7) << 2) | n);
        push_feed((d - 1) >> 3);
      end
      default: begin
        d = $urandom_range((gw < 16384) ? gw : 16384, 1);
        if (f == 2) begin
          len = $urandom_range(33, 3);
          push_feed(32 | (len - 2));
        end else begin
          z = ($urandom_range(4, 0) == 0) ? 1 : 0;
          b = $urandom_range(255, 1);
          len = 255 * z + 33 + b;
          push_feed(32);
          repeat (z) push_feed(0);
          push_feed(b);
        end
        push_feed((((d - 1) & 63) << 2) | n);
        push_feed((d - 1) >> 6);
      end
    endcase
    push_pulls(len);
    gw += len;
    if (n > 0) begin
      push_bytes(n);
      gw += n;
      gstate = 2;
      ga = 0;
    end else gstate = 1;
  endtask

  task automatic gen_group();
    int unsigned n;
    if (gstate == 2 || (gstate == 1 && $urandom_range(9, 0) >= 3)) gen_match(-1, -1);
    else begin
      n = ($urandom_range(5, 0) == 0) ? $urandom_range(300, 19) : $urandom_range(18, 4);
      gen_lits(n);
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || decoded_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_out_len(int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[23:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    olen = v & Max24;
  endtask

  // ---------------- clock, reset, stimulus ----------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int unsigned sel;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.cmd = 1'b0;
    in_if.in_byte = '0;
    out_if.ready = 1'b0;
    fail_cnt = 0;
    sent_cnt = 0;
    ph = PH_FIRST;
    {tok, plen, mdist, trl, alr, bw, bc, olen} = '0;
    gw = 0;
    gstate = 0;
    ga = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_out_len(0);
    write_out_len(Max24);

    // directed opening: all four generated match forms, extended run, trailing literals
    push_feed(21);
    push_feed(8'h00);
    push_feed(8'hFF);
    push_feed(8'h55);
    push_feed(8'hAA);
    gw = 4;
    gstate = 2;
    ga = 1;
    gen_match(1, 2);
    gen_match(0, 0);
    gen_match(2, 1);
    gen_match(3, 0);
    gen_lits(20);
    gen_match(2, 0);
    wait_drained();

    for (int p = 1; p <= 5; p++) begin
      while (sent_cnt < p * 170) gen_group();
      wait_drained();
      write_out_len($urandom_range(Max24, gw + 70000));
    end

    // closing group decides how the stream stops
    sel = $urandom_range(5, 0);
    case (sel)
      0, 1: write_out_len(gw);
      2: write_out_len(gw + 1);
      3: write_out_len(0);
      default: ;
    endcase
    case (sel)
      0, 1, 2: begin
        push_feed(16 | $urandom_range(7, 1));
        push_feed($urandom_range(3, 0));
        push_feed(0);
      end
      3: begin
        push_feed(8'h40);
        push_feed(0);
      end
      4: begin
        // far lookbehind or a pull where a byte is due
        if ($urandom_range(1, 0)) begin
          push_feed(8'h19);
          push_feed(8'hFC);
          push_feed(8'hFF);
        end else request_q.push_back('{1'b1, 8'h00});
      end
      default: begin
        // byte fed while a copy is pending
        push_feed(8'h40);
        push_feed(0);
        push_feed(8'h00);
      end
    endcase
    repeat (4) request_q.push_back('{1'($urandom), 8'($urandom)});
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // ---------------- driver and monitor ----------------
  function automatic bit calm();
    return sent_cnt >= 300 && sent_cnt < 480 && request_q.size() > 0;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (request_q.size() > 0 && (calm() || $urandom_range(99, 0) >= 12)) begin
        in_if.valid <= 1'b1;
        in_if.cmd <= request_q[0].cmd;
        in_if.in_byte <= request_q[0].data;
      end else begin
        in_if.valid <= 1'b0;
      end
      out_if.ready <= calm() || $urandom_range(99, 0) >= 12;
    end
  end

  always @(posedge clk_i) begin
    result_t w;
    if (in_if.valid && in_if.ready) begin
      decode_request(in_if.cmd, in_if.in_byte);
      void'(request_q.pop_front());
    end
    if (out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: kind %0d", out_if.kind);
        fail_cnt++;
      end else begin
        w = decoded_q.pop_front();
        if (out_if.out_byte !== w.out_byte) begin
          $error("out_byte: expected %0h, got %0h", w.out_byte, out_if.out_byte);
          fail_cnt++;
        end
        if (out_if.kind !== w.kind) begin
          $error("kind: expected %0d, got %0d", w.kind, out_if.kind);
          fail_cnt++;
        end
        if (out_if.consumed_count !== w.count) begin
          $error("consumed_count: expected %0d, got %0d", w.count, out_if.consumed_count);
          fail_cnt++;
        end
        if (out_if.last !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, out_if.last);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end
endmodule

// ===== files.f =====
design/lzo_pkg.sv
design/lzo_stream_if.sv
design/lzo_parser.sv
design/lzo_writer.sv
design/lzo1x_stream_decompressor_top.sv
test/tb_lzo1x_stream_decompressor_top.sv
